// ===== hw/rtl/multi_adc_read_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multi-converter read scheduler
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MULTI_ADC_READ_SCHEDULER_DEFINES_SVH
`define MULTI_ADC_READ_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define MARS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");
// Next-cycle implication.
`define MARS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");
`else
`define MARS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define MARS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/mars_pkg.sv =====
// ----------------------------------------------------------------------------
// mars_pkg
// Shared constants, codes and helpers of the multi-converter read scheduler.
// ----------------------------------------------------------------------------
package mars_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int SAMPLE_W  = 24;

  // Input event codes.
  localparam logic MODE_READY = 1'b0;
  localparam logic MODE_DONE  = 1'b1;

  // Result kind codes.
  localparam logic KIND_GRANT  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // Register index (paddr[2]) and reset value.
  localparam logic REG_ENABLED_MASK = 1'b0;
  localparam logic [NUM_SLOTS-1:0] ENABLED_MASK_RESET = 8'hFF;

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;
  typedef logic [SAMPLE_W-1:0]  sample_t;

  // Index of the lowest set bit; zero when the mask is empty.
  function automatic slot_idx_t lowest_set(input slot_mask_t mask);
    slot_idx_t idx;
    idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hw/rtl/multi_adc_read_scheduler.sv =====
// ----------------------------------------------------------------------------
// multi_adc_read_scheduler
// Arbitrates one shared serial bus among up to eight converters and gathers
// their samples into frames.
// ----------------------------------------------------------------------------
// Each input transfer is one event: a converter reports data ready (tuser 0)
// or the bus read of a converter has finished (tuser 1, with its three bytes).
// The scheduler answers with output transfers: a grant (tuser 0) naming the
// converter that may use the bus next, and, when every converter in
// enabled_mask has delivered a sample, one sample transfer (tuser 1) per
// enabled converter in ascending order, followed by any grant. tlast marks
// the final output transfer caused by an event; events for a converter index
// at or above NUM_CONVERTERS are dropped silently and cause no output.
// Timing: an event is registered on input and evaluated, and its results
// go through the result sequencer into the output register. An event that
// causes at most one result leaves room for a new event every cycle while
// the output register is not stalled; an event that completes a frame holds
// the input until its last result leaves the sequencer, which drives one
// output transfer per cycle while the output is not stalled. While a
// finished result waits in the output register, events that cause no result
// are still taken every cycle and one event that causes results can still be
// evaluated; its results then wait in the sequencer and hold the input until
// the output register drains. enabled_mask is at byte address 0 of the
// register port and is meant to be written only while the block is idle.
// ----------------------------------------------------------------------------
`include "multi_adc_read_scheduler_defines.svh"

module multi_adc_read_scheduler #(
  parameter int NUM_CONVERTERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // chip_index[2:0], byte_first[10:3],
                                 // byte_second[18:11], byte_third[26:19], zeros
  input  logic [0:0]  s_tuser,   // mode[0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // target_chip[2:0], sample_value[26:3], zeros
  output logic [0:0]  m_tuser,   // kind[0]
  output logic        m_tlast
);

  // Converters that exist in this build.
  mars_pkg::slot_mask_t live_mask;
  for (genvar g = 0; g < mars_pkg::NUM_SLOTS; g++) begin : g_live
    assign live_mask[g] = (g < NUM_CONVERTERS);
  end

  // Configuration register.
  mars_pkg::slot_mask_t enabled_mask;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == mars_pkg::REG_ENABLED_MASK);
  assign prdata    = (paddr[2] == mars_pkg::REG_ENABLED_MASK)
                     ? {24'd0, enabled_mask} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_mask <= mars_pkg::ENABLED_MASK_RESET;
    end else if (cfg_write) begin
      enabled_mask <= pwdata[mars_pkg::NUM_SLOTS-1:0];
    end
  end

  // Scheduler state.
  mars_pkg::slot_mask_t ready_bits, served_bits, completed_bits;
  logic                 bus_busy;
  mars_pkg::sample_t    frame_samples [mars_pkg::NUM_SLOTS];

  // Input register.
  logic                 in_valid;
  logic                 in_mode;
  mars_pkg::slot_idx_t  in_chip;
  mars_pkg::sample_t    in_sample;

  // Pending results of the event being drained: frame samples, then a grant.
  mars_pkg::slot_mask_t emit_pend;
  logic                 grant_pend;
  mars_pkg::slot_idx_t  grant_chip;

  // Result sequencer: pops one pending result whenever the output register
  // is free or being emptied.
  logic                 out_free, pop;
  mars_pkg::slot_idx_t  emit_idx;
  mars_pkg::slot_mask_t emit_rest, emit_after;
  logic                 grant_after, job_free;

  assign out_free  = !m_tvalid || m_tready;
  assign pop       = ((emit_pend != '0) || grant_pend) && out_free;
  assign emit_idx  = mars_pkg::lowest_set(emit_pend);
  assign emit_rest = emit_pend & (emit_pend - mars_pkg::slot_mask_t'(1));

  always_comb begin
    emit_after  = emit_pend;
    grant_after = grant_pend;
    if (pop) begin
      if (emit_pend != '0) begin
        emit_after = emit_rest;
      end else begin
        grant_after = 1'b0;
      end
    end
  end

  // A new event is evaluated once the previous event's results are all out
  // of the sequencer (or leave it in this very cycle).
  logic process;
  assign job_free = (emit_after == '0) && !grant_after;
  assign process  = in_valid && job_free;
  assign s_tready = !in_valid || process;

  // Event evaluation.
  mars_pkg::slot_mask_t ready_next, served_next, completed_next;
  logic                 busy_next;
  mars_pkg::slot_mask_t new_emit, chip_bit, cand;
  logic                 new_grant, sample_we;
  mars_pkg::slot_idx_t  new_gchip;

  always_comb begin
    ready_next     = ready_bits;
    served_next    = served_bits;
    completed_next = completed_bits;
    busy_next      = bus_busy;
    new_emit       = '0;
    new_grant      = 1'b0;
    new_gchip      = '0;
    sample_we      = 1'b0;
    chip_bit       = mars_pkg::slot_mask_t'(1) << in_chip;
    cand           = '0;
    if (process && live_mask[in_chip]) begin
      if (in_mode == mars_pkg::MODE_DONE) begin
        sample_we      = 1'b1;
        completed_next = completed_bits | chip_bit;
        if (completed_next == enabled_mask) begin
          // Frame complete: send every enabled sample, start a new round.
          new_emit       = enabled_mask;
          completed_next = '0;
          served_next    = '0;
        end
        ready_next = ready_bits & ~chip_bit;
        busy_next  = 1'b0;
      end else begin
        ready_next = ready_bits | chip_bit;
      end
      cand = ready_next & ~served_next & live_mask;
      if (!busy_next && (cand != '0)) begin
        new_grant   = 1'b1;
        new_gchip   = mars_pkg::lowest_set(cand);
        served_next = served_next | (mars_pkg::slot_mask_t'(1) << new_gchip);
        busy_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      ready_bits     <= '0;
      served_bits    <= '0;
      completed_bits <= '0;
      bus_busy       <= 1'b0;
      emit_pend      <= '0;
      grant_pend     <= 1'b0;
      m_tvalid       <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      ready_bits     <= ready_next;
      served_bits    <= served_next;
      completed_bits <= completed_next;
      bus_busy       <= busy_next;
      emit_pend      <= process ? new_emit : emit_after;
      grant_pend     <= process ? new_grant : grant_after;
      if (pop) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode   <= s_tuser[0];
      in_chip   <= s_tdata[2:0];
      in_sample <= {s_tdata[26:19], s_tdata[18:11], s_tdata[10:3]};
    end
    if (sample_we) begin
      frame_samples[in_chip] <= in_sample;
    end
    if (process) begin
      grant_chip <= new_gchip;
    end
    if (pop) begin
      if (emit_pend != '0) begin
        m_tuser[0] <= mars_pkg::KIND_SAMPLE;
        m_tdata    <= {5'd0, frame_samples[emit_idx], emit_idx};
        m_tlast    <= (emit_rest == '0) && !grant_pend;
      end else begin
        m_tuser[0] <= mars_pkg::KIND_GRANT;
        m_tdata    <= {5'd0, mars_pkg::SAMPLE_W'(0), grant_chip};
        m_tlast    <= 1'b1;
      end
    end
  end

  // A busy bus always belongs to a converter served in this round.
  `MARS_ASSERT_IMPL(busy_has_served, clk, rst, bus_busy, served_bits != '0)
  // A grant waiting in the sequencer always has the bus marked busy.
  `MARS_ASSERT_IMPL(grant_pend_busy, clk, rst, grant_pend, bus_busy)
  // Only converters that exist can be marked completed.
  `MARS_ASSERT_IMPL(completed_live, clk, rst, 1'b1, (completed_bits & ~live_mask) == '0)
  // A granting event leaves the grant queued and the bus busy.
  `MARS_ASSERT_NEXT(grant_queued, clk, rst, new_grant, grant_pend && bus_busy)

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read scheduler testbench
// Streams data-ready and read-done events into the scheduler and checks every
// grant and frame sample against a cycle-free model kept in the testbench.
// ----------------------------------------------------------------------------
module tb;

  // The block is built with its full complement of converters.
  localparam int N_CONV      = mars_pkg::NUM_SLOTS;
  localparam int MAX_RESULTS = mars_pkg::NUM_SLOTS + 1;
  // Room for the pipeline and a full frame burst once the streams go quiet.
  localparam int SETTLE_CYCLES = 16;
  // Far above the slowest legal run: every event bursting a full frame while
  // the result side stalls most of the time and the event side idles too.
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_EVENTS_PER_PHASE = 54;
  localparam logic [2:0] ENABLED_MASK_ADDR = {mars_pkg::REG_ENABLED_MASK, 2'b00};

  // One event as it travels on the input stream.
  typedef struct packed {
    logic                mode;
    mars_pkg::slot_idx_t chip;
    logic [7:0]          byte_first;
    logic [7:0]          byte_second;
    logic [7:0]          byte_third;
  } sched_event_t;

  // One result as it is expected on the output stream.
  typedef struct packed {
    logic                kind;
    mars_pkg::slot_idx_t chip;
    mars_pkg::sample_t   value;
    logic                last;
  } sched_result_t;

  // Everything the scheduler remembers between events, plus its register.
  typedef struct packed {
    mars_pkg::slot_mask_t enabled;
    mars_pkg::slot_mask_t ready;
    mars_pkg::slot_mask_t served;
    mars_pkg::slot_mask_t completed;
    logic                 busy;
    logic [mars_pkg::NUM_SLOTS-1:0][mars_pkg::SAMPLE_W-1:0] samples;
  } sched_state_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // chip_index[2:0], byte_first[10:3],
                               // byte_second[18:11], byte_third[26:19], zeros
  logic [0:0]  s_tuser = '0;   // mode[0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // target_chip[2:0], sample_value[26:3], zeros
  logic [0:0]  m_tuser;        // kind[0]
  logic        m_tlast;

  // Events waiting to be sent, and results owed by events already accepted.
  sched_event_t  pending_events[$];
  sched_result_t expected_results[$];

  // The checking copy advances on accepted events; the generating copy runs
  // ahead as events are queued, so that the stimulus can follow the grants.
  sched_state_t        chk_state;
  sched_state_t        gen_state;
  mars_pkg::slot_idx_t gen_grant = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int cycle_count = 0;

  multi_adc_read_scheduler #(
    .NUM_CONVERTERS(N_CONV)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  always #1 clk = ~clk;

  // Works out what one event does to the scheduler and which transfers it
  // causes: a completed frame first, lowest converter first, then at most one
  // grant. The final result of the event carries last.
  function automatic void schedule_event(
      inout sched_state_t st, input logic mode,
      input mars_pkg::slot_idx_t chip, input mars_pkg::sample_t smp,
      output sched_result_t [MAX_RESULTS-1:0] res,
      output int n);
    mars_pkg::slot_mask_t live;
    mars_pkg::slot_mask_t cand;
    logic                 found;
    res = '0;
    n = 0;
    found = 1'b0;
    live = '0;
    for (int i = 0; i < mars_pkg::NUM_SLOTS; i++) begin
      live[i] = (i < N_CONV);
    end
    // Events for converters that do not exist are dropped.
    if (!live[chip]) begin
      return;
    end
    if (mode == mars_pkg::MODE_READY) begin
      st.ready[chip] = 1'b1;
    end else begin
      st.completed[chip] = 1'b1;
      st.samples[chip] = smp;
      if (st.completed == st.enabled) begin
        for (int i = 0; i < mars_pkg::NUM_SLOTS; i++) begin
          if (st.enabled[i]) begin
            res[n] = '{mars_pkg::KIND_SAMPLE, mars_pkg::slot_idx_t'(i),
                       st.samples[i], 1'b0};
            n++;
          end
        end
        st.completed = '0;
        st.served = '0;
      end
      st.ready[chip] = 1'b0;
      st.busy = 1'b0;
    end
    // The bus goes to the lowest converter that is ready and still unserved.
    if (!st.busy) begin
      cand = st.ready & ~st.served & live;
      for (int i = 0; i < mars_pkg::NUM_SLOTS; i++) begin
        if (cand[i] && !found) begin
          found = 1'b1;
          st.served[i] = 1'b1;
          st.busy = 1'b1;
          res[n] = '{mars_pkg::KIND_GRANT, mars_pkg::slot_idx_t'(i),
                     mars_pkg::sample_t'(0), 1'b0};
          n++;
        end
      end
    end
    if (n > 0) begin
      res[n-1].last = 1'b1;
    end
  endfunction

  // Picks a random converter out of a mask; any converter when it is empty.
  function automatic mars_pkg::slot_idx_t pick_chip(input mars_pkg::slot_mask_t mask);
    mars_pkg::slot_idx_t c;
    c = mars_pkg::slot_idx_t'($urandom_range(mars_pkg::NUM_SLOTS - 1));
    while (mask != '0 && !mask[c]) begin
      c = mars_pkg::slot_idx_t'($urandom_range(mars_pkg::NUM_SLOTS - 1));
    end
    return c;
  endfunction

  // Queues one event and lets the generating copy follow it, so that the
  // converter holding the bus is always known.
  task automatic queue_event(input logic mode, input mars_pkg::slot_idx_t chip,
                             input logic [7:0] b1, input logic [7:0] b2,
                             input logic [7:0] b3);
    sched_result_t [MAX_RESULTS-1:0] res;
    int n;
    sched_event_t ev;
    schedule_event(gen_state, mode, chip, {b3, b2, b1}, res, n);
    for (int i = 0; i < n; i++) begin
      if (res[i].kind == mars_pkg::KIND_GRANT) begin
        gen_grant = res[i].chip;
      end
    end
    ev.mode = mode;
    ev.chip = chip;
    ev.byte_first = b1;
    ev.byte_second = b2;
    ev.byte_third = b3;
    pending_events.push_back(ev);
  endtask

  // Mostly well-formed traffic: converters of the frame report data ready, and
  // the converter holding the bus finishes its read. The rest is noise, which
  // includes reads that were never granted and stray converters.
  task automatic queue_random_event();
    logic                 mode;
    mars_pkg::slot_idx_t  chip;
    mars_pkg::slot_mask_t open_chips;
    mars_pkg::slot_mask_t missing;
    mode = mars_pkg::MODE_READY;
    chip = pick_chip('0);
    open_chips = gen_state.enabled & ~gen_state.served;
    missing = gen_state.enabled & ~gen_state.completed;
    if ($urandom_range(99) < 15 || gen_state.enabled == '0) begin
      mode = 1'($urandom_range(1));
      // A stray read of a converter outside the frame stalls frames for the
      // rest of the phase, so only some of them are let through.
      if (mode == mars_pkg::MODE_DONE && !gen_state.enabled[chip]
          && $urandom_range(3) != 0) begin
        mode = mars_pkg::MODE_READY;
      end
    end else if (gen_state.busy && $urandom_range(1) == 1) begin
      // Free the bus; a grant outside the frame is closed by an enabled read.
      mode = mars_pkg::MODE_DONE;
      chip = gen_state.enabled[gen_grant] ? gen_grant : pick_chip(gen_state.enabled);
    end else if (gen_state.busy) begin
      chip = pick_chip(gen_state.enabled);
    end else if (open_chips != '0) begin
      chip = pick_chip(open_chips);
    end else if (missing != '0) begin
      mode = mars_pkg::MODE_DONE;
      chip = pick_chip(missing);
    end
    queue_event(mode, chip, 8'($urandom_range(255)), 8'($urandom_range(255)),
                8'($urandom_range(255)));
  endtask

  // Waits until every queued event has been taken and every owed result has
  // arrived, then lets the block finish any event that causes no result.
  task automatic wait_until_idle();
    while (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes enabled_mask through the register port and reads it back.
  task automatic write_enabled_mask(input mars_pkg::slot_mask_t mask);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ENABLED_MASK_ADDR;
    pwdata <= 32'(mask);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    chk_state.enabled = mask;
    gen_state.enabled = mask;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[mars_pkg::NUM_SLOTS-1:0] !== mask) begin
      $error("enabled_mask: expected %0h, got %0h", mask,
             prdata[mars_pkg::NUM_SLOTS-1:0]);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Event driver. Each accepted transfer is run through the checking copy of
  // the scheduler, and the results it owes are queued. A new event is offered
  // only once the previous one has gone, so tvalid never drops early.
  always @(posedge clk) begin
    sched_result_t [MAX_RESULTS-1:0] res;
    int n;
    sched_event_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        schedule_event(chk_state, s_tuser[0], s_tdata[2:0], s_tdata[26:3], res, n);
        for (int i = 0; i < n; i++) begin
          expected_results.push_back(res[i]);
        end
      end
      if (!s_tvalid || s_tready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev = pending_events.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= ev.mode;
          s_tdata <= {5'b0, ev.byte_third, ev.byte_second, ev.byte_first, ev.chip};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every accepted transfer must match the oldest result owed.
  always @(posedge clk) begin
    sched_result_t exp_res;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transfer: kind %0d, chip %0d, sample %0h",
                 m_tuser[0], m_tdata[2:0], m_tdata[26:3]);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (m_tuser[0] !== exp_res.kind) begin
            $error("kind: expected %0d, got %0d", exp_res.kind, m_tuser[0]);
            mismatches++;
          end
          if (m_tdata[2:0] !== exp_res.chip) begin
            $error("target_chip: expected %0d, got %0d", exp_res.chip, m_tdata[2:0]);
            mismatches++;
          end
          if (m_tdata[26:3] !== exp_res.value) begin
            $error("sample_value: expected %0h, got %0h", exp_res.value, m_tdata[26:3]);
            mismatches++;
          end
          if (m_tlast !== exp_res.last) begin
            $error("last: expected %0d, got %0d", exp_res.last, m_tlast);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** multi_adc_read_scheduler: FAILED **");
      $finish;
    end
  end

  initial begin
    mars_pkg::slot_mask_t mask;
    chk_state = '0;
    chk_state.enabled = mars_pkg::ENABLED_MASK_RESET;
    gen_state = chk_state;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed frame with all converters enabled. Grants go lowest first, a
    // repeated data ready changes nothing, a read that was never granted is
    // taken as is, and a converter served this round is not granted again.
    queue_event(mars_pkg::MODE_READY, 3'd0, 8'h00, 8'h00, 8'h00);
    queue_event(mars_pkg::MODE_READY, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    queue_event(mars_pkg::MODE_READY, 3'd0, 8'h00, 8'h00, 8'h00);
    queue_event(mars_pkg::MODE_DONE,  3'd0, 8'h00, 8'h00, 8'h00);
    queue_event(mars_pkg::MODE_DONE,  3'd3, 8'hFF, 8'hFF, 8'hFF);
    queue_event(mars_pkg::MODE_READY, 3'd7, 8'h00, 8'h00, 8'h00);
    queue_event(mars_pkg::MODE_DONE,  3'd7, 8'hA5, 8'h5A, 8'hC3);
    queue_event(mars_pkg::MODE_READY, 3'd1, 8'h00, 8'h00, 8'h00);
    queue_event(mars_pkg::MODE_READY, 3'd2, 8'h00, 8'h00, 8'h00);
    queue_event(mars_pkg::MODE_READY, 3'd4, 8'h00, 8'h00, 8'h00);
    queue_event(mars_pkg::MODE_READY, 3'd5, 8'h00, 8'h00, 8'h00);
    queue_event(mars_pkg::MODE_READY, 3'd6, 8'h00, 8'h00, 8'h00);
    queue_event(mars_pkg::MODE_DONE,  3'd1, 8'h01, 8'h80, 8'h7F);
    queue_event(mars_pkg::MODE_DONE,  3'd2, 8'hFE, 8'h01, 8'h80);
    queue_event(mars_pkg::MODE_DONE,  3'd4, 8'h55, 8'hAA, 8'h55);
    queue_event(mars_pkg::MODE_DONE,  3'd5, 8'h12, 8'h34, 8'h56);
    // This read completes the frame: eight samples in a burst.
    queue_event(mars_pkg::MODE_DONE,  3'd6, 8'hFF, 8'h00, 8'hFF);
    queue_event(mars_pkg::MODE_READY, 3'd3, 8'h00, 8'h00, 8'h00);
    wait_until_idle();

    // A read of a converter outside the frame leaves a completed bit that no
    // frame can clear until the mask is widened to cover it.
    write_enabled_mask(8'h0F);
    queue_event(mars_pkg::MODE_DONE,  3'd6, 8'h12, 8'h34, 8'h56);
    queue_event(mars_pkg::MODE_READY, 3'd0, 8'h00, 8'h00, 8'h00);
    wait_until_idle();

    // Random phases. Each new mask covers the completed bits left over, so
    // frames can finish again; the empty mask is the one exception.
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          mask = mars_pkg::slot_mask_t'($urandom_range(255)) | gen_state.completed;
          send_idle_pct = 78;
          recv_stall_pct = 0;
        end
        1: begin
          mask = 8'h01 | gen_state.completed;
          send_idle_pct = 0;
          recv_stall_pct = 78;
        end
        2: begin
          mask = 8'h80 | gen_state.completed;
          send_idle_pct = 38;
          recv_stall_pct = 38;
        end
        3: begin
          mask = 8'h00;
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        default: begin
          mask = 8'hFF;
          send_idle_pct = 38;
          recv_stall_pct = 38;
        end
      endcase
      write_enabled_mask(mask);
      repeat (RANDOM_EVENTS_PER_PHASE) queue_random_event();
      wait_until_idle();
    end

    if (mismatches == 0) begin
      $display("** multi_adc_read_scheduler: PASSED **");
    end else begin
      $display("** multi_adc_read_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
